### rtl/matrix3x3_inverse_assert.svh
// assertion helpers for the matrix inverse block
`ifndef MATRIX3X3_INVERSE_ASSERT_SVH
`define MATRIX3X3_INVERSE_ASSERT_SVH

`ifndef SYNTHESIS
`define MI3_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MI3_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MI3_ASSERT_IMP(label, clk, rst, ante, cons)
`define MI3_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/mi3_pkg.sv
package mi3_pkg;
  localparam int WORD_W     = 32;
  localparam int ADJ_W      = 64;
  localparam int DET_W      = 98;
  localparam int DIV_W      = 130;
  localparam int QUO_W      = 32;
  localparam int LANES      = 9;
  localparam int ADJ_DELAY  = 4;
  localparam int PIPE_DEPTH = 40;
  localparam int DET_DELAY  = 33;

  localparam logic [WORD_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] SAT_NEG = 32'h8000_0000;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [ADJ_W-1:0]  adj_t;

  typedef struct packed {
    logic [DET_W-1:0] mag;
    logic             neg;
  } det_info_t;
endpackage

### rtl/mi3_ifs.sv
interface mi3_in_if;
  import mi3_pkg::*;
  logic  valid;
  logic  ready;
  word_t m11, m12, m13, m21, m22, m23, m31, m32, m33;
  modport source(output valid, m11, m12, m13, m21, m22, m23, m31, m32, m33, input ready);
  modport sink(input valid, m11, m12, m13, m21, m22, m23, m31, m32, m33, output ready);
endinterface

interface mi3_out_if;
  import mi3_pkg::*;
  logic  valid;
  logic  ready;
  word_t inv11, inv12, inv13, inv21, inv22, inv23, inv31, inv32, inv33;
  word_t det_value;
  logic  singular;
  modport source(output valid, inv11, inv12, inv13, inv21, inv22, inv23, inv31, inv32,
                 inv33, det_value, singular, input ready);
  modport sink(input valid, inv11, inv12, inv13, inv21, inv22, inv23, inv31, inv32,
               inv33, det_value, singular, output ready);
endinterface

### rtl/mi3_cofactor.sv
module mi3_cofactor (
  input  logic          clk,
  input  logic          adv,
  input  mi3_pkg::word_t m [9],
  output mi3_pkg::adj_t  adj [9],
  output mi3_pkg::word_t row1 [3]
);
  import mi3_pkg::*;

  adj_t  pa [9];
  adj_t  pb [9];
  word_t row1_s1 [3];

  // products of entry pairs
  always_ff @(posedge clk) begin
    if (adv) begin
      pa[0] <= adj_t'(m[4]) * adj_t'(m[8]);
      pb[0] <= adj_t'(m[5]) * adj_t'(m[7]);
      pa[1] <= adj_t'(m[2]) * adj_t'(m[7]);
      pb[1] <= adj_t'(m[1]) * adj_t'(m[8]);
      pa[2] <= adj_t'(m[1]) * adj_t'(m[5]);
      pb[2] <= adj_t'(m[2]) * adj_t'(m[4]);
      pa[3] <= adj_t'(m[5]) * adj_t'(m[6]);
      pb[3] <= adj_t'(m[3]) * adj_t'(m[8]);
      pa[4] <= adj_t'(m[0]) * adj_t'(m[8]);
      pb[4] <= adj_t'(m[2]) * adj_t'(m[6]);
      pa[5] <= adj_t'(m[2]) * adj_t'(m[3]);
      pb[5] <= adj_t'(m[0]) * adj_t'(m[5]);
      pa[6] <= adj_t'(m[3]) * adj_t'(m[7]);
      pb[6] <= adj_t'(m[4]) * adj_t'(m[6]);
      pa[7] <= adj_t'(m[1]) * adj_t'(m[6]);
      pb[7] <= adj_t'(m[0]) * adj_t'(m[7]);
      pa[8] <= adj_t'(m[0]) * adj_t'(m[4]);
      pb[8] <= adj_t'(m[1]) * adj_t'(m[3]);
      for (int i = 0; i < 3; i++) begin
        row1_s1[i] <= m[i];
      end
    end
  end

  // cofactor differences
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < LANES; i++) begin
        adj[i] <= pa[i] - pb[i];
      end
      for (int i = 0; i < 3; i++) begin
        row1[i] <= row1_s1[i];
      end
    end
  end
endmodule

### rtl/mi3_det.sv
module mi3_det (
  input  logic               clk,
  input  logic               adv,
  input  mi3_pkg::word_t     row1 [3],
  input  mi3_pkg::adj_t      cof [3],
  output mi3_pkg::det_info_t info,
  output mi3_pkg::word_t     det_value,
  output logic               zero
);
  import mi3_pkg::*;

  logic [WORD_W-1:0]   emag [3];
  logic [ADJ_W-1:0]    cmag [3];
  logic [2*WORD_W-1:0] pl [3];
  logic [2*WORD_W-1:0] ph [3];
  logic                tneg [3];
  logic signed [DET_W-1:0] term [3];
  logic signed [DET_W-1:0] det;
  logic                zero_s6;
  logic [DET_W-1:0]    rnd;
  logic [DET_W-WORD_W-1:0] rsh;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      emag[i] = row1[i][WORD_W-1] ? WORD_W'(-row1[i]) : WORD_W'(row1[i]);
      cmag[i] = cof[i][ADJ_W-1] ? ADJ_W'(-cof[i]) : ADJ_W'(cof[i]);
    end
  end

  // split 32x64 products
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pl[i]   <= (2*WORD_W)'(emag[i]) * (2*WORD_W)'(cmag[i][WORD_W-1:0]);
        ph[i]   <= (2*WORD_W)'(emag[i]) * (2*WORD_W)'(cmag[i][ADJ_W-1:WORD_W]);
        tneg[i] <= row1[i][WORD_W-1] ^ cof[i][ADJ_W-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        term[i] <= tneg[i] ? -(DET_W'({ph[i], {WORD_W{1'b0}}}) + DET_W'(pl[i]))
                           :  (DET_W'({ph[i], {WORD_W{1'b0}}}) + DET_W'(pl[i]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      det <= term[0] + term[1] + term[2];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      info.neg <= det[DET_W-1];
      info.mag <= det[DET_W-1] ? DET_W'(-det) : DET_W'(det);
      zero_s6  <= (det == '0);
    end
  end

  assign rnd = info.mag + DET_W'(SAT_NEG);
  assign rsh = rnd[DET_W-1:WORD_W];

  // round half away and saturate
  always_ff @(posedge clk) begin
    if (adv) begin
      zero <= zero_s6;
      if (info.neg) begin
        det_value <= (rsh >= (DET_W-WORD_W)'(SAT_NEG)) ? word_t'(SAT_NEG)
                                                      : word_t'(-rsh[WORD_W-1:0]);
      end else begin
        det_value <= (rsh > (DET_W-WORD_W)'(SAT_POS)) ? word_t'(SAT_POS)
                                                     : word_t'(rsh[WORD_W-1:0]);
      end
    end
  end
endmodule

### rtl/mi3_lane.sv
module mi3_lane (
  input  logic               clk,
  input  logic               adv,
  input  mi3_pkg::adj_t      adj,
  input  mi3_pkg::det_info_t info,
  output mi3_pkg::word_t     res
);
  import mi3_pkg::*;

  adj_t              adj_d [ADJ_DELAY];
  logic [ADJ_W-1:0]  amag;
  logic [DIV_W-1:0]  rem [QUO_W+1];
  logic [DIV_W-1:0]  den [QUO_W+1];
  logic [QUO_W-1:0]  quo [QUO_W+1];
  logic              sgn [QUO_W+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      adj_d[0] <= adj;
      for (int k = 1; k < ADJ_DELAY; k++) begin
        adj_d[k] <= adj_d[k-1];
      end
    end
  end

  assign amag = adj_d[ADJ_DELAY-1][ADJ_W-1] ? ADJ_W'(-adj_d[ADJ_DELAY-1])
                                            : ADJ_W'(adj_d[ADJ_DELAY-1]);

  // numerator carries the rounding half
  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0] <= (DIV_W'(amag) << (WORD_W+1)) + DIV_W'(info.mag);
      den[0] <= DIV_W'({info.mag, 1'b0});
      quo[0] <= '0;
      sgn[0] <= adj_d[ADJ_DELAY-1][ADJ_W-1] ^ info.neg;
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    localparam int SH = QUO_W - 1 - k;
    logic [DIV_W-1:0] trial;
    assign trial = den[k] << SH;
    always_ff @(posedge clk) begin
      if (adv) begin
        den[k+1] <= den[k];
        sgn[k+1] <= sgn[k];
        if (rem[k] >= trial) begin
          rem[k+1] <= rem[k] - trial;
          quo[k+1] <= quo[k] | (QUO_W'(1) << SH);
        end else begin
          rem[k+1] <= rem[k];
          quo[k+1] <= quo[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (quo[QUO_W][QUO_W-1]) begin
        res <= sgn[QUO_W] ? word_t'(SAT_NEG) : word_t'(SAT_POS);
      end else begin
        res <= sgn[QUO_W] ? word_t'(-quo[QUO_W]) : word_t'(quo[QUO_W]);
      end
    end
  end
endmodule

### rtl/matrix3x3_inverse.sv
// 3x3 matrix inverse, signed Q16.16, adjugate over determinant.
// in_item carries one matrix (m11..m33) per item; out_item returns the nine
// inverse entries, the determinant and a singular flag.
// Both channels are valid/ready; an item moves when both are high.
// Throughput: one item per cycle while out_item is not stalled. Nine division
// lanes, one per inverse entry, each resolve one quotient bit per stage over
// 32 stages; cofactor products and the determinant run in 7 stages ahead of them.
// Results are rounded to nearest, halves away from zero, and saturated.
// A zero determinant gives zero entries and singular set.
// Reset (rst, synchronous) empties the pipeline and the output register.
// When the receiver stalls, the pipeline keeps filling until an item sits
// in the last stage behind the held output; then in_item.ready drops.
`include "matrix3x3_inverse_assert.svh"

module matrix3x3_inverse (
  input logic clk,
  input logic rst,
  mi3_in_if.sink    in_item,
  mi3_out_if.source out_item
);
  import mi3_pkg::*;

  logic [PIPE_DEPTH:1] v;
  logic      adv;
  logic      load_out;
  word_t     m [9];
  adj_t      adj [9];
  word_t     row1 [3];
  adj_t      cof [3];
  det_info_t info;
  word_t     det_s7;
  logic      zero_s7;
  word_t     res [9];
  word_t     det_dly [DET_DELAY];
  logic      zero_dly [DET_DELAY];

  assign load_out      = !out_item.valid || out_item.ready;
  assign adv           = !v[PIPE_DEPTH] || load_out;
  assign in_item.ready = adv;

  assign m[0] = in_item.m11;
  assign m[1] = in_item.m12;
  assign m[2] = in_item.m13;
  assign m[3] = in_item.m21;
  assign m[4] = in_item.m22;
  assign m[5] = in_item.m23;
  assign m[6] = in_item.m31;
  assign m[7] = in_item.m32;
  assign m[8] = in_item.m33;

  mi3_cofactor u_cof (
    .clk  (clk),
    .adv  (adv),
    .m    (m),
    .adj  (adj),
    .row1 (row1)
  );

  assign cof[0] = adj[0];
  assign cof[1] = adj[3];
  assign cof[2] = adj[6];

  mi3_det u_det (
    .clk       (clk),
    .adv       (adv),
    .row1      (row1),
    .cof       (cof),
    .info      (info),
    .det_value (det_s7),
    .zero      (zero_s7)
  );

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    mi3_lane u_lane (
      .clk  (clk),
      .adv  (adv),
      .adj  (adj[i]),
      .info (info),
      .res  (res[i])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      det_dly[0]  <= det_s7;
      zero_dly[0] <= zero_s7;
      for (int k = 1; k < DET_DELAY; k++) begin
        det_dly[k]  <= det_dly[k-1];
        zero_dly[k] <= zero_dly[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      out_item.valid <= 1'b0;
    end else begin
      if (adv) begin
        v <= {v[PIPE_DEPTH-1:1], in_item.valid};
      end
      if (load_out) begin
        out_item.valid <= v[PIPE_DEPTH];
      end
    end
  end

  // merge lanes with the singular case
  always_ff @(posedge clk) begin
    if (load_out && v[PIPE_DEPTH]) begin
      out_item.singular  <= zero_dly[DET_DELAY-1];
      out_item.det_value <= zero_dly[DET_DELAY-1] ? '0 : det_dly[DET_DELAY-1];
      out_item.inv11 <= zero_dly[DET_DELAY-1] ? '0 : res[0];
      out_item.inv12 <= zero_dly[DET_DELAY-1] ? '0 : res[1];
      out_item.inv13 <= zero_dly[DET_DELAY-1] ? '0 : res[2];
      out_item.inv21 <= zero_dly[DET_DELAY-1] ? '0 : res[3];
      out_item.inv22 <= zero_dly[DET_DELAY-1] ? '0 : res[4];
      out_item.inv23 <= zero_dly[DET_DELAY-1] ? '0 : res[5];
      out_item.inv31 <= zero_dly[DET_DELAY-1] ? '0 : res[6];
      out_item.inv32 <= zero_dly[DET_DELAY-1] ? '0 : res[7];
      out_item.inv33 <= zero_dly[DET_DELAY-1] ? '0 : res[8];
    end
  end

  `MI3_ASSERT_IMP(a_singular_zero, clk, rst, out_item.valid && out_item.singular, out_item.det_value == '0 && out_item.inv11 == '0 && out_item.inv33 == '0)
  `MI3_ASSERT_NEXT(a_enter, clk, rst, in_item.valid && in_item.ready, v[1])
  `MI3_ASSERT_IMP(a_full_stall, clk, rst, v[PIPE_DEPTH] && out_item.valid && !out_item.ready, !in_item.ready)
  `MI3_ASSERT_NEXT(a_drain, clk, rst, v[PIPE_DEPTH] && load_out, out_item.valid)
endmodule
